### sv/aars_pkg.sv
// ============================================================================
// aars_pkg
// shared constants and the queue entry type of the anchor average smoother
// ============================================================================
`default_nettype none

package aars_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int WIN_LEN          = 9;   // samples in one averaging window
    localparam int ANCHOR_SPACING   = 8;   // distance between anchors
    localparam int RAMP_LEN         = 4;   // positions rewritten by a later anchor
    localparam int PHASE_W          = $clog2(ANCHOR_SPACING);
    localparam int SEEN_W           = $clog2(WIN_LEN + 1);
    localparam int IDX_W            = $clog2(WIN_LEN);
    localparam int QUEUE_DEPTH      = 4;

    // classification of one accepted sample
    typedef struct packed {
        logic              last;    // final sample of the stream
        logic              anchor;  // the window is complete around an anchor
        logic              first;   // that anchor is the first of the stream
        logic              emit;    // one delayed word leaves in steady state
        logic [SEEN_W-1:0] cnt;     // samples of the stream held so far
    } entry_ctrl_t;

endpackage

`default_nettype wire

### sv/aars_front.sv
// ============================================================================
// aars_front
// stream position tracking and classification of each accepted sample
// ============================================================================
`default_nettype none

module aars_front #(
    parameter int SAMPLE_WIDTH = aars_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_sample,
    input  wire logic                    s_tlast,
    input  wire logic                    q_ready,
    output logic                         push_valid,
    output logic [SAMPLE_WIDTH-1:0]      push_sample,
    output aars_pkg::entry_ctrl_t        push_ctrl
);
    import aars_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic               first_done_reg, first_done_next;
    logic [SEEN_W-1:0]  seen_inc;
    logic               full;
    logic               anchor;
    logic               accept;

    assign accept   = s_tvalid && q_ready;
    assign seen_inc = (seen_reg == SEEN_W'(WIN_LEN)) ? seen_reg : seen_reg + 1'b1;
    assign full     = (seen_inc == SEEN_W'(WIN_LEN));
    assign anchor   = (phase_reg == '0) && full;

    assign s_tready    = q_ready;
    assign push_valid  = s_tvalid;
    assign push_sample = s_sample;

    always_comb begin
        push_ctrl.last   = s_tlast;
        push_ctrl.anchor = anchor;
        push_ctrl.first  = anchor && !first_done_reg;
        push_ctrl.emit   = full;
        push_ctrl.cnt    = seen_inc;
    end

    always_comb begin
        phase_next      = phase_reg;
        seen_next       = seen_reg;
        first_done_next = first_done_reg;
        if (accept) begin
            if (s_tlast) begin
                // end of stream, next sample starts a new one
                phase_next      = '0;
                seen_next       = '0;
                first_done_next = 1'b0;
            end else begin
                phase_next      = phase_reg + 1'b1;
                seen_next       = seen_inc;
                first_done_next = first_done_reg || anchor;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            seen_reg       <= '0;
            first_done_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            seen_reg       <= seen_next;
            first_done_reg <= first_done_next;
        end
    end

endmodule

`default_nettype wire

### sv/aars_queue.sv
// ============================================================================
// aars_queue
// short first-in first-out queue between the front and the back
// ============================================================================
`default_nettype none

module aars_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = aars_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### sv/aars_back.sv
// ============================================================================
// aars_back
// window mean, ramp arithmetic, delayed output line and end-of-stream flush
// ============================================================================
`default_nettype none

module aars_back #(
    parameter int SAMPLE_WIDTH = aars_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_valid,
    output logic                         q_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] q_sample,
    input  wire aars_pkg::entry_ctrl_t   q_ctrl,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [SAMPLE_WIDTH-1:0]      m_sample,
    output logic                         m_tlast
);
    import aars_pkg::*;

    localparam int W       = SAMPLE_WIDTH;
    localparam int SUM_W   = W + 4;
    localparam int MAG_W   = W + 3;
    localparam int PROD_W  = MAG_W + W;
    localparam int RAMP_W  = W + 3;
    localparam int STAGES  = 6;
    localparam int LAST_ST = STAGES - 1;
    localparam logic [MAG_W:0] RECIP_FULL = {1'b1, {MAG_W{1'b0}}} / (MAG_W + 1)'(WIN_LEN);
    localparam logic [W-1:0]   RECIP      = RECIP_FULL[W-1:0];
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WIN_LEN - 1);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    // original window and its running sum
    logic [W-1:0]            win_reg [WIN_LEN];
    logic signed [SUM_W-1:0] sum_reg;

    // per-stage payload carried along the pipeline
    logic                    valid_reg [STAGES];
    logic [W-1:0]            samp_reg  [STAGES];
    entry_ctrl_t             ctrl_reg  [STAGES];
    logic [W-1:0]            base_reg  [STAGES];

    logic [PROD_W-1:0]       s1_prod_reg;
    logic [MAG_W-1:0]        s1_mag_reg;
    logic                    s1_neg_reg;
    logic [W-1:0]            s2_q0_reg;
    logic                    s2_ge9_reg;
    logic                    s2_neg_reg;
    logic [W-1:0]            s3_mean_reg;
    logic [W-1:0]            s4_mean_reg;
    logic signed [W:0]       s4_step_reg;
    logic [W-1:0]            s5_mean_reg;
    logic [W-1:0]            s5_ramp_reg [RAMP_LEN];

    // delayed output line
    logic [W-1:0]            pend_reg [WIN_LEN];

    logic                    state_reg, state_next;
    logic [IDX_W-1:0]        flush_idx_reg, flush_idx_next;
    logic                    m_tvalid_reg;
    logic [W-1:0]            m_sample_reg;
    logic                    m_tlast_reg;

    logic                    adv;
    logic                    slot_free;
    logic                    apply_ok;
    logic                    load_run;
    logic                    load_flush;
    logic [W-1:0]            run_word;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        sum_abs;
    logic [W-1:0]            q0;
    logic [MAG_W-1:0]        nine_q0;
    logic [MAG_W-1:0]        rem;
    logic [W-1:0]            mean_c;
    logic signed [W:0]       diff_c;
    logic signed [RAMP_W-1:0] stx;
    logic signed [RAMP_W-1:0] bx;
    logic signed [RAMP_W-1:0] ramp_c [RAMP_LEN];

    function automatic logic [W-1:0] sat_w(input logic [RAMP_W-1:0] v);
        logic [W-1:0] r;
        if (v[RAMP_W-1:W-1] == '0 || v[RAMP_W-1:W-1] == '1) begin
            r = v[W-1:0];
        end else if (v[RAMP_W-1]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    // ---------------- pipeline control ----------------
    assign slot_free = !m_tvalid_reg || m_tready;
    assign apply_ok  = valid_reg[LAST_ST] && (state_reg == ST_RUN) &&
                       (ctrl_reg[LAST_ST].last || !ctrl_reg[LAST_ST].emit || slot_free);
    assign adv        = !valid_reg[LAST_ST] || apply_ok;
    assign q_ready    = adv;
    assign load_run   = apply_ok && ctrl_reg[LAST_ST].emit && !ctrl_reg[LAST_ST].last;
    assign load_flush = (state_reg == ST_FLUSH) && slot_free;

    // ---------------- arithmetic ----------------
    assign sum_next = sum_reg + SUM_W'($signed(q_sample)) - SUM_W'($signed(win_reg[0]));
    assign sum_abs  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign q0       = s1_prod_reg[PROD_W-1:MAG_W];
    assign nine_q0  = {q0, 3'b000} + MAG_W'(q0);
    assign rem      = s1_mag_reg - nine_q0;
    // truncation toward zero: correct the magnitude, then apply the sign
    assign mean_c   = s2_neg_reg ? (~s2_q0_reg + W'(!s2_ge9_reg))
                                 : (s2_q0_reg + W'(s2_ge9_reg));
    assign diff_c   = (W + 1)'($signed(s3_mean_reg)) - (W + 1)'($signed(base_reg[3]));
    assign stx      = RAMP_W'(s4_step_reg);
    assign bx       = RAMP_W'($signed(base_reg[4]));

    always_comb begin
        ramp_c[0] = bx + stx;
        ramp_c[1] = bx + (stx <<< 1);
        ramp_c[2] = bx + stx + (stx <<< 1);
        ramp_c[3] = bx + (stx <<< 2);
    end

    // a first anchor rewrites the head of the line; otherwise head is the next entry
    assign run_word = ctrl_reg[LAST_ST].first ? s5_mean_reg : pend_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < WIN_LEN; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (adv) begin
            valid_reg[0] <= q_valid;
            for (int i = 1; i < STAGES; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            if (q_valid) begin
                for (int i = 0; i < WIN_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN_LEN-1] <= q_sample;
                sum_reg            <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            samp_reg[0] <= q_sample;
            ctrl_reg[0] <= q_ctrl;
            base_reg[0] <= win_reg[1];
            for (int i = 1; i < STAGES; i++) begin
                samp_reg[i] <= samp_reg[i-1];
                ctrl_reg[i] <= ctrl_reg[i-1];
                base_reg[i] <= base_reg[i-1];
            end
            s1_prod_reg <= sum_abs[MAG_W-1:0] * RECIP;
            s1_mag_reg  <= sum_abs[MAG_W-1:0];
            s1_neg_reg  <= sum_reg[SUM_W-1];
            s2_q0_reg   <= q0;
            s2_ge9_reg  <= (rem >= MAG_W'(WIN_LEN));
            s2_neg_reg  <= s1_neg_reg;
            s3_mean_reg <= mean_c;
            s4_mean_reg <= s3_mean_reg;
            s4_step_reg <= diff_c >>> 2;
            s5_mean_reg <= s4_mean_reg;
            for (int k = 0; k < RAMP_LEN; k++) begin
                s5_ramp_reg[k] <= sat_w(ramp_c[k]);
            end
        end
    end

    // ---------------- output line ----------------
    // shift by one; an anchor replaces the lead-in (first) or the ramp span
    always_ff @(posedge aclk) begin
        if (apply_ok) begin
            if (ctrl_reg[LAST_ST].anchor && ctrl_reg[LAST_ST].first) begin
                pend_reg[0] <= s5_mean_reg;
            end else begin
                pend_reg[0] <= pend_reg[1];
            end
            for (int i = 1; i <= RAMP_LEN; i++) begin
                if (ctrl_reg[LAST_ST].anchor) begin
                    pend_reg[i] <= ctrl_reg[LAST_ST].first ? s5_mean_reg : s5_ramp_reg[i-1];
                end else begin
                    pend_reg[i] <= pend_reg[i+1];
                end
            end
            for (int i = RAMP_LEN + 1; i < WIN_LEN - 1; i++) begin
                pend_reg[i] <= pend_reg[i+1];
            end
            pend_reg[WIN_LEN-1] <= samp_reg[LAST_ST];
        end
    end

    always_comb begin
        state_next     = state_reg;
        flush_idx_next = flush_idx_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (apply_ok && ctrl_reg[LAST_ST].last) begin
                    state_next     = ST_FLUSH;
                    flush_idx_next = IDX_W'(WIN_LEN) - IDX_W'(ctrl_reg[LAST_ST].cnt);
                end
            end
            ST_FLUSH: begin
                if (load_flush) begin
                    if (flush_idx_reg == LAST_IDX) begin
                        state_next = ST_RUN;
                    end else begin
                        flush_idx_next = flush_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            flush_idx_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            flush_idx_reg <= flush_idx_next;
            if (load_run || load_flush) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_run) begin
            m_sample_reg <= run_word;
            m_tlast_reg  <= 1'b0;
        end else if (load_flush) begin
            m_sample_reg <= pend_reg[flush_idx_reg];
            m_tlast_reg  <= (flush_idx_reg == LAST_IDX);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_sample = m_sample_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- checks ----------------
    a_flush_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH |-> flush_idx_reg <= LAST_IDX)
        else $error("flush index past the end of the output line");

    a_flush_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        load_flush && flush_idx_reg == LAST_IDX |=> state_reg == ST_RUN && m_tlast_reg)
        else $error("flush did not end on the stream's final word");

    a_run_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load_run |=> m_tvalid_reg && !m_tlast_reg)
        else $error("steady-state word marked last");

    a_flush_count: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LAST_ST] && ctrl_reg[LAST_ST].last |->
            ctrl_reg[LAST_ST].cnt != '0 && ctrl_reg[LAST_ST].cnt <= SEEN_W'(WIN_LEN))
        else $error("end-of-stream entry with a bad held count");

endmodule

`default_nettype wire

### sv/anchor_average_ramp_smoother.sv
// ============================================================================
// anchor_average_ramp_smoother
// anchor average smoother with linear ramps, streaming top level
// ============================================================================
// usage
// - s_ channel carries one signed sample per word, s_tlast marks the final
//   sample of a stream; m_ channel carries the smoothed stream in order
// - output runs eight samples behind input: once nine samples of a stream
//   are held, each further sample releases the word from eight positions
//   earlier; s_tlast releases all held words (up to nine), last one tagged
// - throughput is one sample per cycle while m_tready does not stall; the
//   end of a stream holds the back end while it flushes the held words,
//   which the input queue absorbs up to its depth
// - an accepted sample passes through the queue and then six arithmetic
//   stages: running sum, reciprocal multiply, remainder check, sign, step,
//   ramp with saturation
// - a stall on m_tready freezes the back pipeline once its last stage holds
//   an entry that releases a word; the queue fills and then s_tready drops
// - reset clears position counters, queue, pipeline valids and the output
//   valid flag; no words are held afterwards
// ============================================================================
`default_nettype none

module anchor_average_ramp_smoother #(
    parameter int SAMPLE_WIDTH = aars_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0] s_tdata,  // sample_in
    input  wire logic                                  s_tlast,  // last_in
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0]      m_tdata,  // sample_out
    output logic                                       m_tlast   // last_out
);
    import aars_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int ENTRY_W = $bits(entry_ctrl_t) + SAMPLE_WIDTH;

    // front to queue
    logic                    push_valid;
    logic [SAMPLE_WIDTH-1:0] push_sample;
    entry_ctrl_t             push_ctrl;
    logic                    q_in_ready;

    // queue to back
    logic                    q_valid;
    logic                    q_ready;
    logic [ENTRY_W-1:0]      q_data;
    entry_ctrl_t             q_ctrl;
    logic [SAMPLE_WIDTH-1:0] q_sample;

    logic [SAMPLE_WIDTH-1:0] m_sample;

    // classify each sample by its place in the stream
    aars_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_sample    (s_tdata[SAMPLE_WIDTH-1:0]),
        .s_tlast     (s_tlast),
        .q_ready     (q_in_ready),
        .push_valid  (push_valid),
        .push_sample (push_sample),
        .push_ctrl   (push_ctrl)
    );

    // entries: control bits above the sample
    aars_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (q_in_ready),
        .in_data   ({push_ctrl, push_sample}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_sample = q_data[SAMPLE_WIDTH-1:0];
    assign q_ctrl   = q_data[ENTRY_W-1:SAMPLE_WIDTH];

    // averaging, ramps and the delayed output line
    aars_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_sample (q_sample),
        .q_ctrl   (q_ctrl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_sample (m_sample),
        .m_tlast  (m_tlast)
    );

    // pad bits above the sample are zero
    assign m_tdata = TDATA_W'(m_sample);

endmodule

`default_nettype wire
